// ----- rtl/core/acss_pkg.sv -----
package acss_pkg;

  // field widths
  localparam int CH_W       = 4;
  localparam int NUM_CH     = 16;
  localparam int SMP_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int SMOOTH_W   = 4;
  localparam int SETTLE_W   = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // smoothing numerator old*s + new, divisor s + 1
  localparam int NUM_W  = SMP_W + SMOOTH_W;
  localparam int DEN_W  = SMOOTH_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);

  // first channel whose report byte is inverted
  localparam logic [CH_W-1:0] INVERT_FIRST = 4'd6;

  localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = '0;
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 1'b1;

  typedef struct packed {
    logic             conversion_done;
    logic [SMP_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic              start_conversion;
    logic              report_write;
    logic [CH_W-1:0]   report_slot;
    logic [BYTE_W-1:0] report_value;
    logic              value_changed;
    logic [CH_W-1:0]   mux_select;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // channels 0-5 fill faders 5..0, 6-9 the pots 12..15, 10-15 faders 6..11
  function automatic logic [CH_W-1:0] slot_of(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] slot;
    if (ch < 4'd6) begin
      slot = 4'd5 - ch;
    end else if (ch > 4'd9) begin
      slot = ch - 4'd4;
    end else begin
      slot = ch + 4'd6;
    end
    return slot;
  endfunction

endpackage

// ----- rtl/core/adc_channel_scanner_smoother_top.sv -----
// Scans a 16-way analog multiplexer one polling pass per input transaction and
// returns exactly one result transaction per pass. A pass that completes a
// conversion steps through accept, operand read, 14 divider steps, a check
// that the divider has finished, memory write-back and result, paced by the
// shared restoring divider that produces one quotient bit per cycle for
// (old*s + new) / (s + 1). A pass that does not complete a conversion goes
// from accept straight to result. Either pass is lengthened while out_stall
// holds the previous result. Filtered values and report bytes sit in two
// 16-entry synchronous memories whose entries read as zero until written;
// no clearing pass is needed after reset. Write configuration only while idle.
module adc_channel_scanner_smoother_top
  import acss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [SMOOTH_W-1:0] smoothing;
  logic [SETTLE_W-1:0] settle_passes;
  logic [CH_W-1:0]     channel_index;
  logic [SETTLE_W-1:0] pause_count;
  logic                awaiting;
  logic [SMP_W-1:0]    smp;
  out_t                res;

  logic              in_accept;
  logic              out_load;
  logic              div_start;
  logic              div_busy;
  logic [NUM_W-1:0]  div_num;
  logic [NUM_W-1:0]  div_quo;
  logic [SMP_W-1:0]  filt_rdata;
  logic [SMP_W-1:0]  new_value;
  logic [BYTE_W-1:0] rep_rdata;
  logic [BYTE_W-1:0] rep_value;
  logic [CH_W-1:0]   slot;
  logic              mem_we;

  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign slot      = slot_of(channel_index);
  assign new_value = div_quo[SMP_W-1:0];
  assign rep_value = (channel_index >= INVERT_FIRST) ? ~new_value[SMP_W-1:2]
                                                     : new_value[SMP_W-1:2];

  // numerator old*s + new, registered inside the divider
  assign div_num = NUM_W'(filt_rdata * smoothing) + NUM_W'(smp);

  // filtered value per channel
  acss_ram #(
    .WIDTH(SMP_W),
    .DEPTH(NUM_CH)
  ) u_filt_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (mem_we),
    .waddr(channel_index),
    .wdata(new_value),
    .raddr(channel_index),
    .rdata(filt_rdata)
  );

  // last byte written into each report slot
  acss_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(NUM_CH)
  ) u_rep_ram (
    .clk  (clk),
    .rst  (rst),
    .we   (mem_we),
    .waddr(slot),
    .wdata(rep_value),
    .raddr(slot),
    .rdata(rep_rdata)
  );

  acss_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (DEN_W'(smoothing) + 1'b1),
    .busy (div_busy),
    .quo  (div_quo)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (awaiting && in_data.conversion_done) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!div_busy) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing     <= SMOOTH_RESET;
      settle_passes <= SETTLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTHING: smoothing     <= cfg_data[SMOOTH_W-1:0];
        REG_SETTLE:    settle_passes <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // scan control: settle count, conversion request, channel advance
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      pause_count   <= '0;
      awaiting      <= 1'b0;
    end else if (in_accept && !awaiting) begin
      if (pause_count < settle_passes) begin
        pause_count <= pause_count + 1'b1;
      end else begin
        awaiting <= 1'b1;
      end
    end else if (state == ST_WRITE) begin
      channel_index <= channel_index + 1'b1;
      pause_count   <= '0;
      awaiting      <= 1'b0;
    end
  end

  // pending result and captured sample
  always_ff @(posedge clk) begin
    if (in_accept) begin
      smp <= in_data.sample;
      res <= '{start_conversion: !awaiting && (pause_count >= settle_passes),
               report_write:     1'b0,
               report_slot:      '0,
               report_value:     '0,
               value_changed:    1'b0,
               mux_select:       channel_index};
    end else if (state == ST_WRITE) begin
      res <= '{start_conversion: 1'b0,
               report_write:     1'b1,
               report_slot:      slot,
               report_value:     rep_value,
               value_changed:    (rep_rdata != rep_value),
               mux_select:       CH_W'(channel_index + 1'b1)};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  // divider runs only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIVIDE))
    else $error("divider busy outside divide state");

  // a write-back always moves the multiplexer to the next channel
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |=> (channel_index == $past(channel_index) + 4'd1))
    else $error("channel did not advance after write-back");

  // a requested conversion leaves the block waiting for its result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res.start_conversion) |-> awaiting)
    else $error("conversion requested without awaiting result");

  // a pass never both requests a conversion and writes a report slot
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !(res.start_conversion && res.report_write))
    else $error("start and report write in the same pass");

endmodule

// ----- rtl/core/acss_ram.sv -----
module acss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // per-entry valid bits, an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

// ----- rtl/core/acss_divider.sv -----
module acss_divider
  import acss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;

  // one restoring step: bring down the next numerator bit and try a subtract
  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= STEP_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath, quotient bits shift in where numerator bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      if (diff[DEN_W+1]) begin
        rem <= shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end else begin
        rem <= diff[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end
    end
  end

endmodule
